// File: design/plc_pkg.sv
`timescale 1ns / 1ps

package plc_pkg;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_DEL_FRONT = 3'd2,
		CMD_DEL_BACK  = 3'd3,
		CMD_INS_AT    = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_DUMP      = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	typedef struct packed {
		logic exec;
		logic dump_step;
	} ctl_t;

	typedef struct packed {
		logic dump_go;
		logic dump_end;
	} stat_t;

endpackage

// File: design/plc_ctrl.sv
`timescale 1ns / 1ps

module plc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  plc_pkg::stat_t stat,
	output plc_pkg::ctl_t  ctl
);

	plc_pkg::state_t state_q;
	plc_pkg::state_t state_nxt;

	assign busy          = (state_q == plc_pkg::ST_DUMP);
	assign ctl.exec      = start && (state_q == plc_pkg::ST_IDLE);
	assign ctl.dump_step = (state_q == plc_pkg::ST_DUMP);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			plc_pkg::ST_IDLE: begin
				if (ctl.exec && stat.dump_go) begin
					state_nxt = plc_pkg::ST_DUMP;
				end
			end
			plc_pkg::ST_DUMP: begin
				if (stat.dump_end) begin
					state_nxt = plc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = plc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: design/plc_dpath.sv
`timescale 1ns / 1ps

module plc_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  plc_pkg::ctl_t       ctl,
	output plc_pkg::stat_t      stat,
	input  logic         [2:0]  cmd,
	input  logic signed  [31:0] value,
	input  logic         [4:0]  position,
	output logic                strobe,
	output logic         [1:0]  status,
	output logic         [4:0]  entry_count,
	output logic signed  [31:0] element,
	output logic                element_valid,
	output logic                last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = ((CW > 5) ? CW : 5) + 1;

	logic [31:0]     elements_q [CAPACITY];
	logic [31:0]     elem_nxt   [CAPACITY];
	logic [31:0]     up_w       [CAPACITY];
	logic [31:0]     dn_w       [CAPACITY];
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_nxt;
	logic [IW-1:0]   dump_idx_q;

	logic            strobe_q;
	plc_pkg::status_t status_q;
	logic [31:0]     element_q;
	logic            element_valid_q;
	logic            last_q;

	logic [PW-1:0]   pos_w;
	logic [PW-1:0]   cnt_w;
	logic [PW-1:0]   slot;
	logic            ins_req;
	logic            del_req;
	logic            is_at;
	logic            full;
	logic            empty;
	logic            ins_ok;
	logic            del_ok;
	plc_pkg::status_t stat_code;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
		if (g == CAPACITY - 1) begin : g_top
			assign up_w[g] = elements_q[g];
		end else begin : g_mid
			assign up_w[g] = elements_q[g+1];
		end
		if (g == 0) begin : g_bot
			assign dn_w[g] = elements_q[g];
		end else begin : g_low
			assign dn_w[g] = elements_q[g-1];
		end
	end

	assign pos_w = PW'(position);
	assign cnt_w = PW'(count_q);
	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	assign stat.dump_go  = (cmd == plc_pkg::CMD_DUMP) && !empty;
	assign stat.dump_end = (dump_idx_q == IW'(count_q - CW'(1)));

	always_comb begin
		ins_req = 1'b0;
		del_req = 1'b0;
		is_at   = 1'b0;
		slot    = '0;
		case (cmd)
			plc_pkg::CMD_INS_FRONT: begin
				ins_req = 1'b1;
			end
			plc_pkg::CMD_INS_BACK: begin
				ins_req = 1'b1;
				slot    = cnt_w;
			end
			plc_pkg::CMD_INS_AT: begin
				ins_req = 1'b1;
				is_at   = 1'b1;
				slot    = pos_w - PW'(1);
			end
			plc_pkg::CMD_DEL_FRONT: begin
				del_req = 1'b1;
			end
			plc_pkg::CMD_DEL_BACK: begin
				del_req = 1'b1;
				slot    = cnt_w - PW'(1);
			end
			plc_pkg::CMD_DEL_AT: begin
				del_req = 1'b1;
				is_at   = 1'b1;
				slot    = pos_w - PW'(1);
			end
			default: begin
			end
		endcase

		ins_ok = ins_req && !full &&
			(!is_at || ((pos_w != '0) && (pos_w <= cnt_w + PW'(1))));
		del_ok = del_req && !empty &&
			(!is_at || ((pos_w != '0) && (pos_w <= cnt_w)));

		if (ins_req && full) begin
			stat_code = plc_pkg::STAT_FULL;
		end else if (del_req && empty) begin
			stat_code = plc_pkg::STAT_EMPTY;
		end else if ((ins_req && !ins_ok) || (del_req && !del_ok)) begin
			stat_code = plc_pkg::STAT_INVALID;
		end else begin
			stat_code = plc_pkg::STAT_OK;
		end

		count_nxt = count_q;
		if (ctl.exec && ins_ok) begin
			count_nxt = count_q + CW'(1);
		end else if (ctl.exec && del_ok) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			elem_nxt[i] = elements_q[i];
			if (ctl.dump_step) begin
				if (PW'(i) + PW'(1) < cnt_w) begin
					elem_nxt[i] = up_w[i];
				end else if (PW'(i) + PW'(1) == cnt_w) begin
					elem_nxt[i] = elements_q[0];
				end
			end else if (ctl.exec && ins_ok) begin
				if (PW'(i) == slot) begin
					elem_nxt[i] = value;
				end else if (PW'(i) > slot) begin
					elem_nxt[i] = dn_w[i];
				end
			end else if (ctl.exec && del_ok) begin
				if (PW'(i) >= slot) begin
					elem_nxt[i] = up_w[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			elements_q[i] <= elem_nxt[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dump_idx_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			count_q  <= count_nxt;
			strobe_q <= ctl.dump_step || (ctl.exec && !stat.dump_go);
			if (ctl.exec) begin
				dump_idx_q <= '0;
			end else if (ctl.dump_step) begin
				dump_idx_q <= dump_idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dump_step) begin
			status_q        <= plc_pkg::STAT_OK;
			element_q       <= elements_q[0];
			element_valid_q <= 1'b1;
			last_q          <= stat.dump_end;
		end else if (ctl.exec) begin
			status_q        <= stat_code;
			element_q       <= '0;
			element_valid_q <= 1'b0;
			last_q          <= 1'b1;
		end
	end

	assign strobe        = strobe_q;
	assign status        = status_q;
	assign entry_count   = 5'(count_q);
	assign element       = element_q;
	assign element_valid = element_valid_q;
	assign last          = last_q;

endmodule

// File: design/positional_list_store.sv
// Insert, delete, unused codes and an empty dump give one word, in the cycle after start.
// One such command is accepted per cycle while idle; busy stays low.
// Dump of n elements: the state turns ST_DUMP, then each word is taken from cell 0, one per
// cycle as the register chain rotates its occupied cells; busy stays high through the dump.
// Reset clears the count and the controller; element storage is not cleared.
// The receiver cannot stall: each word is on the ports for one cycle, marked by strobe.
`timescale 1ns / 1ps

module positional_list_store #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic        [2:0]  cmd,
	input  logic signed [31:0] value,
	input  logic        [4:0]  position,
	output logic               strobe,
	output logic        [1:0]  status,
	output logic        [4:0]  entry_count,
	output logic signed [31:0] element,
	output logic               element_valid,
	output logic               last
);

	plc_pkg::ctl_t  ctl;
	plc_pkg::stat_t stat;

	plc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	plc_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd),
		.value         (value),
		.position      (position),
		.strobe        (strobe),
		.status        (status),
		.entry_count   (entry_count),
		.element       (element),
		.element_valid (element_valid),
		.last          (last)
	);

endmodule

// File: dv/positional_list_store_check.sv
`timescale 1ns / 1ps

module positional_list_store_check #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic        [2:0]  cmd,
	input  logic signed [31:0] value,
	input  logic        [4:0]  position,
	input  logic               strobe,
	input  logic        [1:0]  status,
	input  logic        [4:0]  entry_count,
	input  logic signed [31:0] element,
	input  logic               element_valid,
	input  logic               last,
	output int                 mismatches,
	output int                 pending
);

	import plc_pkg::*;

	typedef struct {
		status_t            status;
		logic        [4:0]  count;
		logic signed [31:0] element;
		logic               valid;
		logic               last;
	} list_word_t;

	logic signed [31:0] cells [CAPACITY];
	int unsigned stored;
	list_word_t expected_words [$];

	task automatic push_word(status_t st, logic signed [31:0] elem, logic valid, logic fin);
		list_word_t w;
		w.status = st;
		w.count = stored[4:0];
		w.element = elem;
		w.valid = valid;
		w.last = fin;
		expected_words.push_back(w);
	endtask

	task automatic insert_cell(int unsigned slot, logic signed [31:0] v);
		for (int i = int'(stored); i > int'(slot); i--)
			cells[i] = cells[i - 1];
		cells[slot] = v;
		stored++;
	endtask

	task automatic delete_cell(int unsigned slot);
		for (int unsigned i = slot; i + 1 < stored; i++)
			cells[i] = cells[i + 1];
		stored--;
	endtask

	task automatic predict_command(logic [2:0] code, logic signed [31:0] v, logic [4:0] pos);
		status_t st;
		int unsigned p;
		st = STAT_OK;
		p = pos;
		if (code == CMD_DUMP) begin
			if (stored == 0)
				push_word(STAT_OK, '0, 1'b0, 1'b1);
			else
				for (int unsigned i = 0; i < stored; i++)
					push_word(STAT_OK, cells[i], 1'b1, i + 1 == stored);
		end else begin
			case (code)
				CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
					if (stored >= CAPACITY)
						st = STAT_FULL;
					else if (code == CMD_INS_FRONT)
						insert_cell(0, v);
					else if (code == CMD_INS_BACK)
						insert_cell(stored, v);
					else if (p < 1 || p > stored + 1)
						st = STAT_INVALID;
					else
						insert_cell(p - 1, v);
				end
				CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
					if (stored == 0)
						st = STAT_EMPTY;
					else if (code == CMD_DEL_FRONT)
						delete_cell(0);
					else if (code == CMD_DEL_BACK)
						delete_cell(stored - 1);
					else if (p < 1 || p > stored)
						st = STAT_INVALID;
					else
						delete_cell(p - 1);
				end
				default: ;
			endcase
			push_word(st, '0, 1'b0, 1'b1);
		end
	endtask

	always @(posedge clk) begin
		list_word_t exp;
		logic bad;
		if (arst_n) begin
			if (strobe !== 1'b0) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: status %0d count %0d element %0d valid %b last %b",
							status, entry_count, element, element_valid, last);
				end else begin
					exp = expected_words.pop_front();
					bad = 1'b0;
					if (strobe !== 1'b1) bad = 1'b1;
					if (status !== exp.status) bad = 1'b1;
					if (entry_count !== exp.count) bad = 1'b1;
					if (element !== exp.element) bad = 1'b1;
					if (element_valid !== exp.valid) bad = 1'b1;
					if (last !== exp.last) bad = 1'b1;
					if (bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word mismatch: exp status %0d count %0d element %0d valid %b last %b",
								exp.status, exp.count, exp.element, exp.valid, exp.last,
								" / got status %0d count %0d element %0d valid %b last %b",
								status, entry_count, element, element_valid, last);
					end
				end
			end
			if (start && !busy)
				predict_command(cmd, value, position);
		end
		pending = expected_words.size();
	end

endmodule

// File: dv/positional_list_store_test.sv
`timescale 1ns / 1ps

module positional_list_store_test;

	import plc_pkg::*;

	localparam int CAPACITY = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 340;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	typedef enum int {
		BIAS_DRAIN,
		BIAS_MIXED,
		BIAS_FILL
	} bias_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic        [2:0]  cmd = '0;
	logic signed [31:0] value = '0;
	logic        [4:0]  position = '0;
	logic               busy;
	logic               strobe;
	logic        [1:0]  status;
	logic        [4:0]  entry_count;
	logic signed [31:0] element;
	logic               element_valid;
	logic               last;

	int mismatches;
	int pending;
	int cycles = 0;
	int burst_left = 0;

	always #2 clk = ~clk;

	positional_list_store #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.value(value),
		.position(position),
		.strobe(strobe),
		.status(status),
		.entry_count(entry_count),
		.element(element),
		.element_valid(element_valid),
		.last(last)
	);

	positional_list_store_check #(.CAPACITY(CAPACITY)) list_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.value(value),
		.position(position),
		.strobe(strobe),
		.status(status),
		.entry_count(entry_count),
		.element(element),
		.element_valid(element_valid),
		.last(last),
		.mismatches(mismatches),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("positional_list_store_test: done, errors");
			$finish;
		end
	end

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			start <= 1'b0;
			cmd <= 3'($urandom);
			value <= $urandom;
			position <= 5'($urandom);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
		end
	endtask

	task automatic issue(logic [2:0] c, logic signed [31:0] v, logic [4:0] p);
		logic was_busy;
		start <= 1'b1;
		cmd <= c;
		value <= v;
		position <= p;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		pace();
	endtask

	// hold off until every expected word has come out
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (CAPACITY + 4) @(posedge clk);
	endtask

	function automatic logic signed [31:0] any_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_word(bias_t bias);
		int r;
		int ins_pct;
		logic [4:0] p;
		r = $urandom_range(0, 99);
		ins_pct = (bias == BIAS_FILL) ? 75 : (bias == BIAS_DRAIN) ? 20 : 50;
		p = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(1, CAPACITY + 1));
		if (r < 8)
			issue(CMD_DUMP, any_value(), p);
		else if (r < 9)
			issue(CMD_UNUSED, any_value(), p);
		else if ($urandom_range(0, 99) < ins_pct)
			case ($urandom_range(0, 2))
				0: issue(CMD_INS_FRONT, any_value(), p);
				1: issue(CMD_INS_BACK, any_value(), p);
				default: issue(CMD_INS_AT, any_value(), p);
			endcase
		else
			case ($urandom_range(0, 2))
				0: issue(CMD_DEL_FRONT, any_value(), p);
				1: issue(CMD_DEL_BACK, any_value(), p);
				default: issue(CMD_DEL_AT, any_value(), p);
			endcase
	endtask

	initial begin
		bias_t order [4];
		order = '{BIAS_DRAIN, BIAS_MIXED, BIAS_FILL, BIAS_MIXED};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		issue(CMD_DEL_FRONT, '0, 5'd1);
		issue(CMD_DEL_BACK, '0, 5'd1);
		issue(CMD_DEL_AT, '0, 5'd5);
		issue(CMD_DUMP, '0, '0);
		issue(CMD_UNUSED, '0, '0);
		issue(CMD_INS_AT, 32'sh1234, 5'd0);
		issue(CMD_INS_AT, 32'sh1234, 5'd2);
		issue(CMD_INS_AT, 32'sh80000000, 5'd1);
		issue(CMD_INS_FRONT, 32'sh7fffffff, '0);
		issue(CMD_INS_BACK, -32'sd1, '0);
		issue(CMD_DEL_AT, '0, 5'd0);
		issue(CMD_DEL_AT, '0, 5'd31);
		issue(CMD_INS_AT, 32'sh5a5a, 5'd31);
		issue(CMD_INS_AT, '0, 5'd4);
		issue(CMD_DUMP, '0, '0);
		issue(CMD_DEL_AT, '0, 5'd2);
		issue(CMD_DEL_BACK, '0, '0);
		issue(CMD_DEL_FRONT, '0, '0);
		// fill to capacity, then push against the full store
		for (int i = 0; i < CAPACITY - 1; i++)
			issue(CMD_INS_BACK, (i % 2) ? 32'shaaaaaaaa : 32'sh55555555, '0);
		issue(CMD_INS_FRONT, 32'sh11, '0);
		issue(CMD_INS_BACK, 32'sh22, '0);
		issue(CMD_INS_AT, 32'sh33, 5'd1);
		issue(CMD_DUMP, '0, '0);
		issue(CMD_DEL_AT, '0, 5'(CAPACITY));
		issue(CMD_UNUSED, -32'sd1, 5'd31);
		settle();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			random_word(order[(n / 40) % 4]);
			if (n == RANDOM_WORDS / 2)
				settle();
		end
		settle();

		if (mismatches == 0)
			$display("positional_list_store_test: done, clean");
		else
			$display("positional_list_store_test: done, errors");
		$finish;
	end

endmodule
